### design/lsf_pkg.sv
// ----------------------------------------------------------------------------
// Line substring filter package
// Shared constants, codes and payload types for the line substring filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int LINE_CAPACITY = 256;
    localparam int PATTERN_MAX   = 8;

    localparam int WIN_DEPTH   = 8;
    localparam int PATTERN_W   = 64;
    localparam int PLEN_W      = 4;
    localparam int DATA_W      = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int COUNT_W     = $clog2(LINE_CAPACITY);
    localparam int ACT_LEN_W   = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W       = (COUNT_W > ACT_LEN_W) ? COUNT_W : ACT_LEN_W;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] EXIT_MATCH    = 2'd0;
    localparam logic [1:0] EXIT_NO_MATCH = 2'd1;
    localparam logic [1:0] EXIT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic       line_valid;
        logic       line_matched;
        logic [7:0] line_length;
        logic       line_truncated;
        logic       stream_done;
        logic       any_match;
        logic       any_overflow;
        logic [1:0] exit_status;
    } t_out_item;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [ACT_LEN_W-1:0] act_len;
    } t_cfg;

endpackage

### design/lsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// Line substring filter configuration registers
// Holds the pattern and its length and presents the clamped active length.
// ----------------------------------------------------------------------------
module lsf_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsf_pkg::DATA_W-1:0]    i_cfg_data,
    output lsf_pkg::t_cfg                 o_cfg
);
    import lsf_pkg::*;

    logic [PATTERN_W-1:0] r_pattern;
    logic [PLEN_W-1:0]    r_plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PATTERN_BYTES: begin
                    r_pattern <= i_cfg_data[PATTERN_W-1:0];
                end
                REG_PATTERN_LENGTH: begin
                    r_plen <= i_cfg_data[PLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.pattern = r_pattern;
        if (r_plen > PLEN_W'(PATTERN_MAX)) begin
            o_cfg.act_len = ACT_LEN_W'(PATTERN_MAX);
        end else begin
            o_cfg.act_len = r_plen[ACT_LEN_W-1:0];
        end
    end

endmodule

### design/lsf_in_stage.sv
// ----------------------------------------------------------------------------
// Line substring filter input stage
// Registers one incoming transaction and stalls only while it is held.
// ----------------------------------------------------------------------------
module lsf_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lsf_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output lsf_pkg::t_in_item o_item
);
    import lsf_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

### design/lsf_line_core.sv
// ----------------------------------------------------------------------------
// Line substring filter line core
// Window compare, line state, sticky flags and the result register.
// ----------------------------------------------------------------------------
module lsf_line_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsf_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  lsf_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lsf_pkg::t_out_item o_out_item
);
    import lsf_pkg::*;

    logic [WIN_DEPTH-1:0][7:0] r_win;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_found;
    logic                      r_match_seen;
    logic                      r_ovf_seen;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [WIN_DEPTH-1:0][7:0] n_win;
    logic [COUNT_W-1:0]        n_count;
    logic                      n_found;
    logic                      n_match_seen;
    logic                      n_ovf_seen;
    t_out_item                 n_out;
    logic                      emit;
    logic                      hit;
    logic                      room;
    logic [PATTERN_MAX:0]      len_hits;
    logic                      win_hit;
    logic [COUNT_W+7:0]        count_ext;

    assign o_take      = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign room      = r_count < COUNT_W'(LINE_CAPACITY - 1);
    assign hit       = r_found || (i_cfg.act_len == '0);
    assign count_ext = {8'd0, r_count};

    always_comb begin
        n_win = {r_win[WIN_DEPTH-2:0], i_item.byte_value};
        len_hits[0] = 1'b1;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            len_hits[l] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (n_win[l-1-j] != i_cfg.pattern[8*j +: 8]) begin
                    len_hits[l] = 1'b0;
                end
            end
        end
        win_hit = len_hits[i_cfg.act_len]
               && (CMP_W'(r_count + 1'b1) >= CMP_W'(i_cfg.act_len));
    end

    always_comb begin
        n_count      = r_count;
        n_found      = r_found;
        n_match_seen = r_match_seen;
        n_ovf_seen   = r_ovf_seen;
        emit         = 1'b1;
        n_out        = '0;
        if (i_item.kind == KIND_END) begin
            if (r_count != '0) begin
                n_out.line_valid   = 1'b1;
                n_out.line_matched = hit;
                n_out.line_length  = count_ext[7:0];
                n_match_seen       = r_match_seen || hit;
            end
            n_count = '0;
            n_found = 1'b0;
            n_out.stream_done = 1'b1;
        end else if (i_item.byte_value == NEWLINE_CHAR || !room) begin
            n_out.line_valid     = 1'b1;
            n_out.line_matched   = hit;
            n_out.line_length    = count_ext[7:0];
            n_out.line_truncated = !(i_item.byte_value == NEWLINE_CHAR);
            n_match_seen         = r_match_seen || hit;
            n_ovf_seen           = r_ovf_seen || !(i_item.byte_value == NEWLINE_CHAR);
            n_count              = '0;
            n_found              = 1'b0;
        end else begin
            emit    = 1'b0;
            n_count = r_count + 1'b1;
            n_found = r_found || win_hit;
        end
        n_out.any_match    = n_match_seen;
        n_out.any_overflow = n_ovf_seen;
        if (n_out.stream_done) begin
            if (n_ovf_seen) begin
                n_out.exit_status = EXIT_OVERFLOW;
            end else if (n_match_seen) begin
                n_out.exit_status = EXIT_MATCH;
            end else begin
                n_out.exit_status = EXIT_NO_MATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_count      <= '0;
            r_found      <= 1'b0;
            r_match_seen <= 1'b0;
            r_ovf_seen   <= 1'b0;
        end else if (o_take) begin
            if (i_item.kind == KIND_DATA && i_item.byte_value != NEWLINE_CHAR && room) begin
                r_win <= n_win;
            end
            r_count      <= n_count;
            r_found      <= n_found;
            r_match_seen <= n_match_seen;
            r_ovf_seen   <= n_ovf_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(LINE_CAPACITY - 1))
        else $error("stored count beyond line capacity");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.kind == KIND_END) |=> (r_count == '0 && !r_found))
        else $error("end of stream did not clear the line state");

    a_no_line_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.line_valid) |->
        (!r_out.line_matched && r_out.line_length == '0 && !r_out.line_truncated))
        else $error("line fields set without a line");

    a_trunc_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.line_truncated) |-> (r_ovf_seen && r_out.any_overflow))
        else $error("truncated line without overflow flag");
`endif

endmodule

### design/line_substring_filter_unit.sv
// Output path: a result passes through the input register and then the result register,
// and is held in the result register while the output stalls.
// Throughput: one input transaction per cycle while the output is not stalled; the window
// compare and line update fit in the single stage between the input register and the result register.
// Reset: synchronous and active low; it clears the window, line count, sticky flags,
// pattern registers and both valid registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Line substring filter unit
// Splits a byte stream into lines and reports whether each line contains a
// configured fixed pattern of up to eight bytes, with end-of-stream status.
// ----------------------------------------------------------------------------
module line_substring_filter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsf_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lsf_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lsf_pkg::t_out_item            o_out_item
);
    import lsf_pkg::*;

    t_cfg     cfg;
    logic     stg_valid;
    logic     stg_take;
    t_in_item stg_item;

    lsf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_valid (stg_valid),
        .i_take  (stg_take),
        .o_item  (stg_item)
    );

    lsf_line_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (stg_valid),
        .i_item      (stg_item),
        .o_take      (stg_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
